### src/assert_macros.svh
// Assertion helpers for the files that check their own logic.
// Every macro samples on the rising edge of i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the synchronous reset is released.
`define ILIR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ILIR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### src/ilir_pkg.sv
package ilir_pkg;

    // Capacity of the list; field widths below are fixed by the request format.
    localparam int DEPTH  = 256;
    localparam int WORD_W = 32;
    localparam int POS_W  = 9;
    localparam int CNT_W  = 9;
    localparam int FUNC_W = 3;
    localparam int ST_W   = 2;

    // The read path ORs cells in groups, then ORs the registered group results.
    localparam int GRP_W  = 4;
    localparam int GRP    = 1 << GRP_W;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
    localparam int GSEL_W = POS_W - GRP_W;

    // Request functions.
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd4;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // Cell update operations.
    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_WR  = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic             en;
        logic [1:0]       op;
        logic [POS_W-1:0] at;
        t_word            word;
    } t_cell_ctl;

endpackage

### src/ilir_req_if.sv
interface ilir_req_if;
    logic                          valid;
    logic                          ready;
    logic [ilir_pkg::FUNC_W-1:0]   func;
    logic [ilir_pkg::POS_W-1:0]    position;
    logic signed [ilir_pkg::WORD_W-1:0] word_in;

    modport source (output valid, output func, output position, output word_in,
                    input ready);
    modport sink   (input valid, input func, input position, input word_in,
                    output ready);
endinterface

### src/ilir_rsp_if.sv
interface ilir_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [ilir_pkg::WORD_W-1:0] word_out;
    logic [ilir_pkg::CNT_W-1:0]    count_now;
    logic [ilir_pkg::ST_W-1:0]     status;

    modport source (output valid, output word_out, output count_now, output status,
                    input ready);
    modport sink   (input valid, input word_out, input count_now, input status,
                    output ready);
endinterface

### src/ilir_cell.sv
module ilir_cell (
    input  logic                       i_clk,
    input  ilir_pkg::t_cell_ctl        i_ctl,
    input  logic [ilir_pkg::POS_W-1:0] i_idx,
    input  ilir_pkg::t_word            i_lo,
    input  ilir_pkg::t_word            i_hi,
    output ilir_pkg::t_word            o_word
);

    ilir_pkg::t_word r_word;
    ilir_pkg::t_word n_word;

    // Insert pulls the lower neighbor in above the slot, remove pulls the upper one down.
    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            ilir_pkg::OP_INS: begin
                if (i_idx > i_ctl.at) begin
                    n_word = i_lo;
                end else if (i_idx == i_ctl.at) begin
                    n_word = i_ctl.word;
                end
            end
            ilir_pkg::OP_DEL: begin
                if (i_idx >= i_ctl.at) begin
                    n_word = i_hi;
                end
            end
            ilir_pkg::OP_WR: begin
                if (i_idx == i_ctl.at) begin
                    n_word = i_ctl.word;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### src/ilir_rd_grp.sv
module ilir_rd_grp (
    input  ilir_pkg::t_word            i_words [ilir_pkg::GRP],
    input  logic                       i_hit,
    input  logic [ilir_pkg::GRP_W-1:0] i_lane,
    output ilir_pkg::t_word            o_word
);

    // One lane at most is selected, so an OR of the masked words is the mux.
    always_comb begin
        o_word = '0;
        for (int j = 0; j < ilir_pkg::GRP; j++) begin
            if (i_hit && (i_lane == ilir_pkg::GRP_W'(j))) begin
                o_word = o_word | i_words[j];
            end
        end
    end

endmodule

### src/indexed_list_insert_remove_core.sv
// Ordered list of up to DEPTH signed 32-bit words held in a row of cells, one
// word per cell. Requests arrive on i_req (append, insert, remove, read,
// overwrite) and each produces exactly one transfer on o_rsp carrying the word
// read, the element count after the request and a status code. Insert and
// remove move every later word by one place at once, because each cell loads
// from its neighbor in parallel. For append, insert, remove, overwrite and
// every failing request the result sits in the output register on the cycle
// after acceptance. A successful read goes through the read path: the cells
// are ORed in groups of GRP into a register and the group registers are then
// ORed into the output register. The next request is accepted once the read
// sequencer is idle and the output register is empty or being drained in the
// same cycle, so a stalled consumer holds off at most one result. The word
// store has no reset and needs no clearing pass; only the element count, the
// read state and the output valid flag are cleared by i_rst_n.
`include "assert_macros.svh"

module indexed_list_insert_remove_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilir_req_if.sink   i_req,
    ilir_rsp_if.source o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD1  = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [ilir_pkg::CNT_W-1:0] r_count;
    logic [ilir_pkg::CNT_W-1:0] n_count;
    logic [ilir_pkg::POS_W-1:0] r_pos;

    logic                       r_ov;
    ilir_pkg::t_word            r_word;
    logic [ilir_pkg::CNT_W-1:0] r_cnt;
    logic [ilir_pkg::ST_W-1:0]  r_st;

    ilir_pkg::t_word            r_part [ilir_pkg::NGRP];
    ilir_pkg::t_word            w_part [ilir_pkg::NGRP];
    ilir_pkg::t_word            w_cell [ilir_pkg::DEPTH];
    ilir_pkg::t_word            w_tree;

    logic                       acc;
    logic                       full;
    logic                       pos_in;
    logic                       pos_ins;
    logic [ilir_pkg::ST_W-1:0]  dec_st;
    logic                       dec_rd;
    ilir_pkg::t_cell_ctl        ctl;

    assign i_req.ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign acc         = i_req.valid && i_req.ready;

    assign full    = (r_count == ilir_pkg::CNT_W'(ilir_pkg::DEPTH));
    assign pos_in  = (i_req.position < r_count);
    assign pos_ins = (i_req.position <= r_count);

    // Decode the request against the current count. Failing requests leave
    // the cells and the count untouched.
    always_comb begin
        dec_st   = ilir_pkg::ST_OK;
        dec_rd   = 1'b0;
        ctl.en   = 1'b0;
        ctl.op   = ilir_pkg::OP_WR;
        ctl.at   = i_req.position;
        ctl.word = i_req.word_in;
        n_count  = r_count;
        case (i_req.func)
            ilir_pkg::FN_APPEND: begin
                if (full) begin
                    dec_st = ilir_pkg::ST_FULL;
                end else begin
                    ctl.en  = acc;
                    ctl.op  = ilir_pkg::OP_INS;
                    ctl.at  = r_count;
                    n_count = r_count + 1'b1;
                end
            end
            ilir_pkg::FN_INSERT: begin
                if (full) begin
                    dec_st = ilir_pkg::ST_FULL;
                end else if (!pos_ins) begin
                    dec_st = ilir_pkg::ST_RANGE;
                end else begin
                    ctl.en  = acc;
                    ctl.op  = ilir_pkg::OP_INS;
                    n_count = r_count + 1'b1;
                end
            end
            ilir_pkg::FN_REMOVE: begin
                if (!pos_in) begin
                    dec_st = ilir_pkg::ST_RANGE;
                end else begin
                    ctl.en  = acc;
                    ctl.op  = ilir_pkg::OP_DEL;
                    n_count = r_count - 1'b1;
                end
            end
            ilir_pkg::FN_READ: begin
                if (!pos_in) begin
                    dec_st = ilir_pkg::ST_RANGE;
                end else begin
                    dec_rd = 1'b1;
                end
            end
            ilir_pkg::FN_WRITE: begin
                if (!pos_in) begin
                    dec_st = ilir_pkg::ST_RANGE;
                end else begin
                    ctl.en = acc;
                    ctl.op = ilir_pkg::OP_WR;
                end
            end
            default: begin
                dec_st = ilir_pkg::ST_RANGE;
            end
        endcase
    end

    // The row of cells. The ends see zero from the missing neighbor; the low one
    // is never loaded, and the high one only on a remove, past the new count.
    for (genvar i = 0; i < ilir_pkg::DEPTH; i++) begin : g_cell
        ilir_pkg::t_word lo;
        ilir_pkg::t_word hi;
        if (i == 0) begin : g_first
            assign lo = '0;
        end else begin : g_lo
            assign lo = w_cell[i-1];
        end
        if (i == ilir_pkg::DEPTH - 1) begin : g_last
            assign hi = '0;
        end else begin : g_hi
            assign hi = w_cell[i+1];
        end
        ilir_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_idx  (ilir_pkg::POS_W'(i)),
            .i_lo   (lo),
            .i_hi   (hi),
            .o_word (w_cell[i])
        );
    end

    // First level of the read tree; lanes past the end of the row read zero.
    for (genvar g = 0; g < ilir_pkg::NGRP; g++) begin : g_grp
        ilir_pkg::t_word words [ilir_pkg::GRP];
        for (genvar j = 0; j < ilir_pkg::GRP; j++) begin : g_lane
            if (g * ilir_pkg::GRP + j < ilir_pkg::DEPTH) begin : g_used
                assign words[j] = w_cell[g*ilir_pkg::GRP+j];
            end else begin : g_pad
                assign words[j] = '0;
            end
        end
        ilir_rd_grp u_grp (
            .i_words (words),
            .i_hit   (r_pos[ilir_pkg::POS_W-1:ilir_pkg::GRP_W] ==
                      ilir_pkg::GSEL_W'(g)),
            .i_lane  (r_pos[ilir_pkg::GRP_W-1:0]),
            .o_word  (w_part[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD1) begin
            r_part <= w_part;
        end
    end

    // Second level: only the selected group register is non-zero.
    always_comb begin
        w_tree = '0;
        for (int g = 0; g < ilir_pkg::NGRP; g++) begin
            w_tree = w_tree | r_part[g];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && dec_rd) begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_count <= n_count;
            end
            if ((acc && !dec_rd) || (r_state == S_RD2)) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output register and the latched read index.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pos <= i_req.position;
            r_cnt <= n_count;
            r_st  <= dec_st;
            if (!dec_rd) begin
                r_word <= '0;
            end
        end else if (r_state == S_RD2) begin
            r_word <= w_tree;
        end
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.word_out  = r_word;
    assign o_rsp.count_now = r_cnt;
    assign o_rsp.status    = r_st;

    `ILIR_ASSERT_ALWAYS(a_count_cap, (!i_rst_n) || (r_count <= ilir_pkg::CNT_W'(ilir_pkg::DEPTH)), "count above capacity")
    `ILIR_ASSERT(a_count_hold, (!acc) |=> $stable(r_count), "count moved without a request")
    `ILIR_ASSERT(a_read_seq, (acc && dec_rd) |=> (r_state == S_RD1) ##1 (r_state == S_RD2), "read sequence broken")
    `ILIR_ASSERT(a_rd2_free, (r_state == S_RD2) |-> !r_ov, "read result would overwrite a pending result")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

    // Function codes the block does not define; each must be rejected.
    localparam logic [ilir_pkg::FUNC_W-1:0] FN_BAD_A = 3'd5;
    localparam logic [ilir_pkg::FUNC_W-1:0] FN_BAD_B = 3'd6;
    localparam logic [ilir_pkg::FUNC_W-1:0] FN_BAD_C = 3'd7;

    localparam ilir_pkg::t_word W_MAX = 32'sh7FFF_FFFF;
    localparam ilir_pkg::t_word W_MIN = 32'sh8000_0000;

    localparam int RAND_ITEMS = 1400;

    typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} t_phase;

    typedef struct packed {
        ilir_pkg::t_word            word;
        logic [ilir_pkg::CNT_W-1:0] cnt;
        logic [ilir_pkg::ST_W-1:0]  st;
    } t_list_result;

    // One directed request; the result is typed in when check_fixed is set.
    typedef struct packed {
        logic [ilir_pkg::FUNC_W-1:0] func;
        logic [ilir_pkg::POS_W-1:0]  pos;
        ilir_pkg::t_word             word;
        logic                        check_fixed;
        t_list_result                fixed;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilir_req_if req_if();
    ilir_rsp_if rsp_if();

    indexed_list_insert_remove_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the list contents and the expected responses in flight.
    ilir_pkg::t_word list_mirror [ilir_pkg::DEPTH];
    int unsigned     mirror_len;
    t_list_result    pending_results [$];

    int error_count    = 0;
    int results_checked = 0;
    int op_seen [8];
    int full_seen      = 0;
    int range_seen     = 0;
    int peak_len       = 0;
    int burst_left     = 0;

    // Computes the response to one request and updates the mirror.
    function automatic t_list_result apply_list_request(
        input logic [ilir_pkg::FUNC_W-1:0] fn,
        input logic [ilir_pkg::POS_W-1:0]  at,
        input ilir_pkg::t_word             w);
        t_list_result r;
        int unsigned i;
        r.word = '0;
        r.st   = ilir_pkg::ST_OK;
        op_seen[fn]++;
        case (fn)
            ilir_pkg::FN_APPEND, ilir_pkg::FN_INSERT: begin
                if (mirror_len >= ilir_pkg::DEPTH) begin
                    r.st = ilir_pkg::ST_FULL;
                end else if (fn == ilir_pkg::FN_INSERT && at > mirror_len) begin
                    r.st = ilir_pkg::ST_RANGE;
                end else begin
                    if (fn == ilir_pkg::FN_APPEND) at = ilir_pkg::POS_W'(mirror_len);
                    for (i = mirror_len; i > at; i--) list_mirror[i] = list_mirror[i-1];
                    list_mirror[at] = w;
                    mirror_len++;
                end
            end
            ilir_pkg::FN_REMOVE: begin
                if (at >= mirror_len) begin
                    r.st = ilir_pkg::ST_RANGE;
                end else begin
                    for (i = at; i + 1 < mirror_len; i++) list_mirror[i] = list_mirror[i+1];
                    mirror_len--;
                end
            end
            ilir_pkg::FN_READ: begin
                if (at >= mirror_len) r.st = ilir_pkg::ST_RANGE;
                else r.word = list_mirror[at];
            end
            ilir_pkg::FN_WRITE: begin
                if (at >= mirror_len) r.st = ilir_pkg::ST_RANGE;
                else list_mirror[at] = w;
            end
            default: begin
                r.st = ilir_pkg::ST_RANGE;
            end
        endcase
        r.cnt = ilir_pkg::CNT_W'(mirror_len);
        if (r.st == ilir_pkg::ST_FULL) full_seen++;
        if (r.st == ilir_pkg::ST_RANGE) range_seen++;
        if (int'(mirror_len) > peak_len) peak_len = int'(mirror_len);
        return r;
    endfunction

    // Presents one request, pacing the sender in bursts, and records the
    // expected response once the transfer has happened.
    task automatic issue_request(input logic [ilir_pkg::FUNC_W-1:0] fn,
                                 input logic [ilir_pkg::POS_W-1:0]  at,
                                 input ilir_pkg::t_word             w,
                                 input logic                        use_fixed,
                                 input t_list_result                fixed);
        t_list_result predicted;
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        req_if.valid    <= 1'b1;
        req_if.func     <= fn;
        req_if.position <= at;
        req_if.word_in  <= w;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = apply_list_request(fn, at, w);
        pending_results.push_back(use_fixed ? fixed : predicted);
    endtask

    // Holds the sender off until every outstanding response has arrived.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    t_step_row steps [25] = '{
        '{ilir_pkg::FN_READ,   9'd0,   32'sd0,  1'b1, '{32'sd0, 9'd0, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_REMOVE, 9'd0,   32'sd0,  1'b1, '{32'sd0, 9'd0, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_WRITE,  9'd0,   -32'sd1, 1'b1, '{32'sd0, 9'd0, ilir_pkg::ST_RANGE}},
        '{FN_BAD_A,            9'd0,   32'sd0,  1'b1, '{32'sd0, 9'd0, ilir_pkg::ST_RANGE}},
        '{FN_BAD_C,            9'd511, W_MIN,   1'b1, '{32'sd0, 9'd0, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_INSERT, 9'd1,   32'sd1,  1'b1, '{32'sd0, 9'd0, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_INSERT, 9'd0,   W_MAX,   1'b1, '{32'sd0, 9'd1, ilir_pkg::ST_OK}},
        '{ilir_pkg::FN_APPEND, 9'd511, W_MIN,   1'b1, '{32'sd0, 9'd2, ilir_pkg::ST_OK}},
        '{ilir_pkg::FN_READ,   9'd0,   32'sd0,  1'b1, '{W_MAX,  9'd2, ilir_pkg::ST_OK}},
        '{ilir_pkg::FN_READ,   9'd1,   32'sd0,  1'b1, '{W_MIN,  9'd2, ilir_pkg::ST_OK}},
        '{ilir_pkg::FN_READ,   9'd2,   32'sd0,  1'b1, '{32'sd0, 9'd2, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_INSERT, 9'd2,   32'sd0,  1'b1, '{32'sd0, 9'd3, ilir_pkg::ST_OK}},
        '{ilir_pkg::FN_INSERT, 9'd1,   -32'sd1, 1'b0, '0},
        '{ilir_pkg::FN_READ,   9'd1,   32'sd0,  1'b0, '0},
        '{ilir_pkg::FN_READ,   9'd3,   32'sd0,  1'b0, '0},
        '{ilir_pkg::FN_WRITE,  9'd0,   32'sh5555_5555, 1'b0, '0},
        '{ilir_pkg::FN_WRITE,  9'd4,   32'sd7,  1'b1, '{32'sd0, 9'd4, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_READ,   9'd256, 32'sd0,  1'b1, '{32'sd0, 9'd4, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_READ,   9'd0,   32'sd0,  1'b0, '0},
        '{ilir_pkg::FN_REMOVE, 9'd1,   32'sd0,  1'b0, '0},
        '{ilir_pkg::FN_REMOVE, 9'd0,   32'sd0,  1'b0, '0},
        '{ilir_pkg::FN_READ,   9'd0,   32'sd0,  1'b0, '0},
        '{FN_BAD_B,            9'd2,   32'sd0,  1'b1, '{32'sd0, 9'd2, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_INSERT, 9'd256, 32'shAAAA_AAAA, 1'b1,
          '{32'sd0, 9'd2, ilir_pkg::ST_RANGE}},
        '{ilir_pkg::FN_REMOVE, 9'd511, 32'sd0,  1'b1, '{32'sd0, 9'd2, ilir_pkg::ST_RANGE}}
    };

    // Stimulus: directed table, then phases that fill the list to capacity,
    // mix all operations, and drain it back to empty.
    initial begin
        t_phase                      phase;
        t_phase                      phase_order [4];
        int                          phase_idx;
        int                          phase_len;
        int                          extra;
        int                          n;
        int                          rand_sent;
        int unsigned                 r;
        logic [ilir_pkg::FUNC_W-1:0] fn;
        logic [ilir_pkg::POS_W-1:0]  at;
        ilir_pkg::t_word             w;

        phase_order = '{PH_FILL, PH_MIX, PH_DRAIN, PH_MIX};
        phase_idx = 0;
        rand_sent = 0;
        mirror_len = 0;
        foreach (list_mirror[k]) list_mirror[k] = '0;
        foreach (op_seen[k]) op_seen[k] = 0;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = ilir_pkg::FN_APPEND;
        req_if.position = '0;
        req_if.word_in  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[k])
            issue_request(steps[k].func, steps[k].pos, steps[k].word,
                          steps[k].check_fixed, steps[k].fixed);
        wait_for_results();

        while (rand_sent < RAND_ITEMS) begin
            phase = phase_order[phase_idx % 4];
            phase_idx++;
            phase_len = (phase == PH_MIX) ? $urandom_range(60, 160) : 900;
            extra = $urandom_range(8, 24);
            n = 0;
            while (n < phase_len && rand_sent < RAND_ITEMS) begin
                r = $urandom_range(0, 99);
                case (phase)
                    PH_FILL: begin
                        if (r < 45) fn = ilir_pkg::FN_APPEND;
                        else if (r < 78) fn = ilir_pkg::FN_INSERT;
                        else if (r < 85) fn = ilir_pkg::FN_READ;
                        else if (r < 91) fn = ilir_pkg::FN_WRITE;
                        else if (r < 96) fn = ilir_pkg::FN_REMOVE;
                        else fn = FN_BAD_A;
                    end
                    PH_DRAIN: begin
                        if (r < 65) fn = ilir_pkg::FN_REMOVE;
                        else if (r < 77) fn = ilir_pkg::FN_READ;
                        else if (r < 85) fn = ilir_pkg::FN_WRITE;
                        else if (r < 91) fn = ilir_pkg::FN_INSERT;
                        else if (r < 96) fn = ilir_pkg::FN_APPEND;
                        else fn = FN_BAD_A;
                    end
                    default: begin
                        if (r < 18) fn = ilir_pkg::FN_APPEND;
                        else if (r < 36) fn = ilir_pkg::FN_INSERT;
                        else if (r < 58) fn = ilir_pkg::FN_REMOVE;
                        else if (r < 78) fn = ilir_pkg::FN_READ;
                        else if (r < 93) fn = ilir_pkg::FN_WRITE;
                        else fn = FN_BAD_A;
                    end
                endcase
                if (fn == FN_BAD_A) fn = ilir_pkg::FUNC_W'($urandom_range(FN_BAD_A, FN_BAD_C));

                // Mostly legal indices, with the boundaries and the whole
                // 9-bit range mixed in.
                r = $urandom_range(0, 99);
                if (r < 10)
                    at = ilir_pkg::POS_W'($urandom_range(0, 511));
                else if (r < 20)
                    at = ilir_pkg::POS_W'(mirror_len);
                else if (r < 28)
                    at = (mirror_len == 0) ? '0 : ilir_pkg::POS_W'(mirror_len - 1);
                else
                    at = ilir_pkg::POS_W'($urandom_range(0, mirror_len));

                r = $urandom_range(0, 99);
                if (r < 12) begin
                    case ($urandom_range(0, 3))
                        0: w = W_MAX;
                        1: w = W_MIN;
                        2: w = '0;
                        default: w = -32'sd1;
                    endcase
                end else begin
                    w = ilir_pkg::t_word'($urandom);
                end

                issue_request(fn, at, w, 1'b0, '0);
                n++;
                rand_sent++;

                // Stay a little while at the full or empty boundary so that
                // the rejections there are exercised, then move on.
                if ((phase == PH_FILL && mirror_len == ilir_pkg::DEPTH) ||
                    (phase == PH_DRAIN && mirror_len == 0)) begin
                    if (extra == 0) phase_len = n;
                    else extra--;
                end
            end
            wait_for_results();
        end

        repeat (10) @(posedge i_clk);

        $write("Checked %0d responses: %0d append, %0d insert, ",
               results_checked, op_seen[ilir_pkg::FN_APPEND], op_seen[ilir_pkg::FN_INSERT]);
        $display("%0d remove, %0d read, %0d overwrite, %0d undefined-code requests.",
                 op_seen[ilir_pkg::FN_REMOVE], op_seen[ilir_pkg::FN_READ],
                 op_seen[ilir_pkg::FN_WRITE],
                 op_seen[FN_BAD_A] + op_seen[FN_BAD_B] + op_seen[FN_BAD_C]);
        $display("Rejected %0d on a full list, %0d on a bad index; peak fill %0d of %0d.",
                 full_seen, range_seen, peak_len, ilir_pkg::DEPTH);
        if (error_count == 0) begin
            $display("** indexed_list_insert_remove_core: PASSED **");
        end else begin
            $display("** indexed_list_insert_remove_core: FAILED **");
        end
        $finish;
    end

    // Response side back-pressure, switching between several patterns,
    // always-ready stretches among them.
    int   stall_mode      = 0;
    int   stall_mode_left = 0;
    int   hold_left       = 0;
    logic hold_level      = 1'b1;

    initial rsp_if.ready = 1'b0;

    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
        end
        stall_mode_left--;
        case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= ($urandom_range(0, 4) != 0);
            default: begin
                if (hold_left == 0) begin
                    hold_level = ~hold_level;
                    hold_left  = hold_level ? $urandom_range(1, 4) : $urandom_range(1, 8);
                end
                hold_left--;
                rsp_if.ready <= hold_level;
            end
        endcase
    end

    // Every response transfer is matched against the oldest expectation.
    t_list_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected response: word_out %0d count_now %0d status %0d",
                       rsp_if.word_out, rsp_if.count_now, rsp_if.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (rsp_if.word_out !== want.word) begin
                    $error("word_out: expected %0d, got %0d", want.word, rsp_if.word_out);
                    error_count++;
                end
                if (rsp_if.count_now !== want.cnt) begin
                    $error("count_now: expected %0d, got %0d", want.cnt, rsp_if.count_now);
                    error_count++;
                end
                if (rsp_if.status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, rsp_if.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** indexed_list_insert_remove_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/ilir_pkg.sv
src/ilir_req_if.sv
src/ilir_rsp_if.sv
src/ilir_cell.sv
src/ilir_rd_grp.sv
src/indexed_list_insert_remove_core.sv
verif/tb.sv
